// ===== sv/velocity_median_and_stance_detect_macros.svh =====
// Assertion macros shared by the velocity median and stance detect RTL.
`ifndef VELOCITY_MEDIAN_AND_STANCE_DETECT_MACROS_SVH
`define VELOCITY_MEDIAN_AND_STANCE_DETECT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is held.
`define VMSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define VMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VMSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMSD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/vmsd_pkg.sv =====
// Shared constants and types for the velocity median and stance detect block.
package vmsd_pkg;

    // Depth of the speed window and the sorted position that is reported.
    localparam int WINDOW     = 11;
    localparam int MEDIAN_IDX = WINDOW / 2;
    localparam int AGE_W      = $clog2(WINDOW);

    // Number of legs checked for stance; only six height fields exist.
    localparam int LEGS           = 6;
    localparam int NUM_LEG_FIELDS = 6;

    // Field widths.
    localparam int POS_W   = 32;
    localparam int MAG_W   = 32;
    localparam int RATE_W  = 10;
    localparam int SPEED_W = 31;
    localparam int PROD_W  = MAG_W + RATE_W;

    // Stream payload widths.
    localparam int S_TDATA_W = POS_W * (1 + NUM_LEG_FIELDS);
    localparam int M_TDATA_W = 72;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0] RATE_FACTOR_RESET = RATE_W'(10);

    // Register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STANCE_THRESHOLD = 1'b0,
        REG_RATE_FACTOR      = 1'b1
    } cfg_reg_t;

    // What one cell of the sorted window shows its neighbours.
    typedef struct packed {
        logic [SPEED_W-1:0] value;    // stored speed
        logic [AGE_W-1:0]   age;      // transfers since this speed entered
        logic               le;       // stored speed is at or below the new one
        logic               pre_old;  // the oldest entry sits here or further down
    } cell_info_t;

    localparam cell_info_t CELL_TIE_OFF = '{value: '0, age: '0, le: 1'b0, pre_old: 1'b0};

endpackage

// ===== sv/vmsd_cell.sv =====
// One cell of the sorted speed window: holds a speed and its age.
module vmsd_cell import vmsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               upd,        // a new speed enters this cycle
    input  logic [SPEED_W-1:0] new_value,
    input  logic [AGE_W-1:0]   init_age,   // age given at reset, unique per cell
    input  logic               has_left,
    input  logic               has_right,
    input  cell_info_t         left,
    input  cell_info_t         right,
    output cell_info_t         info,
    output logic [SPEED_W-1:0] nxt_value
);

    logic [SPEED_W-1:0] value_reg, value_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic               oldest;
    logic               pre_old;
    logic               self_le;

    // Entry kept at this position once the oldest is dropped, and the one below it.
    logic [SPEED_W-1:0] keep_value, below_value;
    logic [AGE_W-1:0]   keep_age, below_age;
    logic               keep_le, below_le, shift_up;

    assign oldest  = (age_reg == AGE_W'(WINDOW - 1));
    assign pre_old = left.pre_old | oldest;
    assign self_le = (value_reg <= new_value);

    assign info = '{value: value_reg, age: age_reg, le: self_le, pre_old: pre_old};

    // Close the gap left by the oldest entry, then open one for the new speed.
    always_comb begin
        if (pre_old) begin
            keep_value = right.value;
            keep_age   = right.age;
            keep_le    = has_right & right.le;
        end else begin
            keep_value = value_reg;
            keep_age   = age_reg;
            keep_le    = self_le;
        end
        if (left.pre_old) begin
            below_value = value_reg;
            below_age   = age_reg;
            below_le    = self_le;
        end else begin
            below_value = left.value;
            below_age   = left.age;
            below_le    = left.le;
        end
        shift_up = has_left & ~below_le;

        priority if (keep_le) begin
            value_next = keep_value;
            age_next   = keep_age + AGE_W'(1);
        end else if (shift_up) begin
            value_next = below_value;
            age_next   = below_age + AGE_W'(1);
        end else begin
            value_next = new_value;
            age_next   = '0;
        end
    end

    assign nxt_value = value_next;

    // The window starts as all zeros with distinct ages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            age_reg   <= init_age;
        end else if (upd) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

// ===== sv/vmsd_window.sv =====
// Chain of cells that keeps the speed window sorted and yields its median.
`include "velocity_median_and_stance_detect_macros.svh"

module vmsd_window import vmsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               upd,
    input  logic [SPEED_W-1:0] new_value,
    output logic [SPEED_W-1:0] median_next
);

    cell_info_t         info [WINDOW];
    logic [SPEED_W-1:0] nxt  [WINDOW];
    logic [WINDOW-1:0]  oldest_vec;

    // Each cell sees its two neighbours; the ends see a tied-off neighbour.
    for (genvar j = 0; j < WINDOW; j++) begin : g_cell
        cell_info_t left_info, right_info;

        if (j == 0) begin : g_first
            assign left_info = CELL_TIE_OFF;
        end else begin : g_inner_left
            assign left_info = info[j-1];
        end
        if (j == WINDOW - 1) begin : g_last
            assign right_info = CELL_TIE_OFF;
        end else begin : g_inner_right
            assign right_info = info[j+1];
        end

        vmsd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .upd       (upd),
            .new_value (new_value),
            .init_age  (AGE_W'(j)),
            .has_left  (j != 0),
            .has_right (j != WINDOW - 1),
            .left      (left_info),
            .right     (right_info),
            .info      (info[j]),
            .nxt_value (nxt[j])
        );

        assign oldest_vec[j] = (info[j].age == AGE_W'(WINDOW - 1));
    end

    // The median is the middle cell as it stands after this update.
    assign median_next = nxt[MEDIAN_IDX];

    // Exactly one entry is due to leave the window.
    `VMSD_ASSERT(a_one_oldest, aclk, aresetn, $onehot(oldest_vec), "one oldest entry expected")

    // Cells stay in ascending order.
    for (genvar j = 0; j < WINDOW - 1; j++) begin : g_sorted_chk
        `VMSD_ASSERT(a_sorted, aclk, aresetn, info[j].value <= info[j+1].value, "cells unsorted")
    end

    // Without a new speed the window holds still.
    `VMSD_ASSERT(a_hold, aclk, aresetn, !upd |=> $stable(oldest_vec), "ages moved while idle")

endmodule

// ===== sv/velocity_median_and_stance_detect.sv =====
// Top level of the velocity median and stance detect block.
//
// The input stream carries one tick per transfer: body y and six leg heights,
// signed Q16.16 metres. Each tick gives exactly one result transfer holding
// the stance mask, the raw speed |dy| * rate_factor (saturated to 2^31-1) and
// the median of the last eleven raw speeds.
// The input transfer registers |dy| and the stance compares, the speed
// scaled by the rate factor is registered after that, and then it moves
// through the sorted cell chain into the output register. One tick is
// taken every cycle while the output is free.
// When the receiver stalls, the whole pipeline holds and s_tready falls, so
// no result is lost; s_tready follows m_tready once the output register is full.
// Reset clears the window and the previous position to zero, sets the stance
// threshold to 0 and the rate factor to 10, and empties the pipeline. The user
// must have configuration written while the block is idle; it is not enforced.
module velocity_median_and_stance_detect import vmsd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input ticks.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // body_y, leg_z_0, leg_z_1, leg_z_2, leg_z_3, leg_z_4, leg_z_5 (32 bits each)
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Results.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // speed_median (31), speed_raw (31), stance_mask (6), zero fill (4)
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic signed [POS_W-1:0]  thr_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic signed [POS_W-1:0]  prev_y_reg;

    logic                     a_valid_reg;
    logic [MAG_W-1:0]         a_mag_reg, a_mag_next;
    logic [5:0]               a_mask_reg, a_mask_next;

    logic                     b_valid_reg;
    logic [SPEED_W-1:0]       b_raw_reg, b_raw_next;
    logic [5:0]               b_mask_reg;

    logic                     m_valid_reg;
    logic [SPEED_W-1:0]       median_reg, raw_reg;
    logic [5:0]               mask_reg;

    logic                     en, in_xfer, upd;
    logic signed [POS_W-1:0]  body_y;
    logic signed [POS_W:0]    diff;
    logic [PROD_W-1:0]        prod;
    logic [SPEED_W-1:0]       median_next;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en       = ~m_valid_reg | m_tready;
    assign s_tready = en;
    assign in_xfer  = s_tvalid & en;
    assign upd      = en & b_valid_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= '0;
            rate_reg <= RATE_FACTOR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_STANCE_THRESHOLD: thr_reg  <= $signed(cfg_wr_data[POS_W-1:0]);
                REG_RATE_FACTOR:      rate_reg <= cfg_wr_data[RATE_W-1:0];
            endcase
        end
    end

    // First stage: exact position change and stance compares.
    assign body_y = $signed(s_tdata[POS_W-1:0]);
    assign diff   = {body_y[POS_W-1], body_y} - {prev_y_reg[POS_W-1], prev_y_reg};

    always_comb begin
        logic [POS_W:0] neg;
        neg        = -diff;
        a_mag_next = diff[POS_W] ? neg[MAG_W-1:0] : diff[MAG_W-1:0];
        a_mask_next = '0;
        for (int k = 0; k < NUM_LEG_FIELDS; k++) begin
            if (k < LEGS) begin
                a_mask_next[k] = ($signed(s_tdata[POS_W*(k+1) +: POS_W]) <= thr_reg);
            end
        end
    end

    // Second stage: scale by the rate factor and saturate.
    assign prod       = PROD_W'(a_mag_reg) * PROD_W'(rate_reg);
    assign b_raw_next = (|prod[PROD_W-1:SPEED_W]) ? '1 : prod[SPEED_W-1:0];

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_y_reg  <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            if (s_tvalid) begin
                prev_y_reg <= body_y;
            end
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            a_mag_reg  <= a_mag_next;
            a_mask_reg <= a_mask_next;
        end
        if (en) begin
            b_raw_reg  <= b_raw_next;
            b_mask_reg <= a_mask_reg;
        end
        if (upd) begin
            median_reg <= median_next;
            raw_reg    <= b_raw_reg;
            mask_reg   <= b_mask_reg;
        end
    end

    // Sorted window of the last raw speeds.
    vmsd_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd         (upd),
        .new_value   (b_raw_reg),
        .median_next (median_next)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2*SPEED_W - 6)'(0), mask_reg, raw_reg, median_reg};

endmodule
